>>> design/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define CHK_IMPL(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

`define CHK_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

>>> design/nlps_pkg.sv
package nlps_pkg;

  localparam int unsigned PosW   = 24;
  localparam int unsigned QuatW  = 16;
  localparam int unsigned YawW   = 16;
  localparam int unsigned RadW   = 49;
  localparam int unsigned DistW  = 50;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned TrigW  = 16;
  localparam int unsigned HeadW  = 36;
  localparam int unsigned ProdW  = 52;

  localparam logic [14:0] SinA = 15'd25736;
  localparam logic [13:0] SinB = 14'd10512;
  localparam logic [10:0] SinC = 11'd1160;
  localparam logic [14:0] QOne = 15'd16384;

  typedef struct packed {
    logic signed [PosW-1:0]  object_x;
    logic signed [PosW-1:0]  object_y;
    logic signed [QuatW-1:0] quat_w;
    logic signed [QuatW-1:0] quat_x;
    logic signed [QuatW-1:0] quat_y;
    logic signed [QuatW-1:0] quat_z;
    logic signed [PosW-1:0]  point_x;
    logic signed [PosW-1:0]  point_y;
    logic [YawW-1:0]         point_yaw;
    logic [RadW-1:0]         point_radius_sq;
    logic                    in_junction;
    logic                    last_point;
  } point_item_t;

  typedef struct packed {
    logic                   found;
    logic [IdxW-1:0]        best_index;
    logic signed [PosW-1:0] best_x;
    logic signed [PosW-1:0] best_y;
    logic [YawW-1:0]        best_yaw;
    logic [RadW-1:0]        best_dist_sq;
  } search_result_t;

  // classified item passed from front to back
  typedef struct packed {
    logic                   keep_ok;
    logic [DistW-1:0]       sq_dist;
    logic [RadW-1:0]        radius;
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic [YawW-1:0]        yaw;
    logic                   last;
  } cand_t;

endpackage

>>> design/nlps_if.sv
interface nlps_in_if (input logic clk);
  logic                 valid;
  logic                 ready;
  nlps_pkg::point_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface nlps_out_if (input logic clk);
  logic                    valid;
  logic                    ready;
  nlps_pkg::search_result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

>>> design/nearest_lane_point_search_unit.sv
// channel   dir   payload
// in_ch     in    one lane point with object pose
// out_ch    out   search result, one per query
// accepts one point per cycle while ready; back end registers a result on the last point
// front is a five-stage pipeline (products, sine polynomial, heading dot product)
// a two-entry queue decouples front from the compare-and-keep back end
// rst is synchronous and clears pipeline, queue and search state
// a stalled output holds the back end, which fills the queue and then stalls input
`include "assert_macros.svh"

module nearest_lane_point_search_unit #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input logic    clk,
  input logic    rst,
  nlps_in_if.sink     in_ch,
  nlps_out_if.source  out_ch
);

  logic            f_valid, f_ready, q_valid, q_ready;
  nlps_pkg::cand_t f_cand, q_cand;

  nlps_front u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch),
    .cand_valid(f_valid), .cand_ready(f_ready), .cand(f_cand)
  );

  nlps_queue u_queue (
    .clk(clk), .rst(rst),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_cand),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_cand)
  );

  nlps_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk(clk), .rst(rst),
    .cand_valid(q_valid), .cand_ready(q_ready), .cand(q_cand),
    .out_ch(out_ch)
  );

  `CHK_IMPL(a_no_result_on_miss, out_ch.valid && !out_ch.data.found,
            out_ch.data.best_dist_sq == '1, "miss must carry all-ones distance")
  `CHK_NEXT(a_result_raised_by_last, !out_ch.valid || out_ch.ready,
            !out_ch.valid || $past(q_valid && q_cand.last), "result without last item")
  `CHK_IMPL(a_queue_drain_stall, out_ch.valid && !out_ch.ready,
            !q_ready, "back end advanced while output stalled")

endmodule

>>> design/nlps_front.sv
module nlps_front (
  input  logic                  clk,
  input  logic                  rst,
  nlps_in_if.sink               in_ch,
  output logic                  cand_valid,
  input  logic                  cand_ready,
  output nlps_pkg::cand_t       cand
);

  // stage 1: products and quarter-wave indices
  logic                  s1_valid, s2_valid, s3_valid, s4_valid, s5_valid;
  logic                  adv;
  nlps_pkg::point_item_t s1_it;
  logic signed [33:0]    s1_wz, s1_xy, s1_yy, s1_zz;
  logic signed [48:0]    s1_dx2, s1_dy2;
  logic [14:0]           s1_zc, s1_zs;
  logic                  s1_negc, s1_negs;

  // stage 2 onward carry these
  logic [nlps_pkg::DistW-1:0]       s2_dist, s3_dist, s4_dist, s5_dist;
  logic signed [nlps_pkg::HeadW-1:0] s2_hs, s2_hc, s3_hs, s3_hc, s4_hs, s4_hc;
  logic [14:0]  s2_zc, s2_zs, s3_zc, s3_zs, s4_zc, s4_zs;
  logic [14:0]  s2_z2c, s2_z2s;
  logic         s2_negc, s2_negs, s3_negc, s3_negs, s4_negc, s4_negs;
  logic [14:0]  s3_tc, s3_ts;
  logic signed [nlps_pkg::TrigW-1:0] s4_lc, s4_ls;
  logic         s2_j, s3_j, s4_j, s5_j, s5_neg;
  logic [nlps_pkg::RadW-1:0] s2_r, s3_r, s4_r, s5_r;
  logic signed [nlps_pkg::PosW-1:0] s2_px, s2_py, s3_px, s3_py, s4_px, s4_py, s5_px, s5_py;
  logic [nlps_pkg::YawW-1:0] s2_yaw, s3_yaw, s4_yaw, s5_yaw;
  logic         s2_last, s3_last, s4_last, s5_last;

  logic [15:0]  yaw_c;
  logic signed [24:0] dx, dy;
  logic [31:0]  sq_c, sq_s;
  logic [25:0]  m_c, m_s;
  logic [29:0]  t2_c, t2_s;
  logic [29:0]  sn_c, sn_s;
  logic signed [nlps_pkg::ProdW-1:0] pc, ps, dot;

  assign adv = !s5_valid || cand_ready;
  assign in_ch.ready = adv;
  assign cand_valid = s5_valid;

  assign yaw_c = in_ch.data.point_yaw + 16'd16384;
  assign dx = 25'(in_ch.data.object_x) - 25'(in_ch.data.point_x);
  assign dy = 25'(in_ch.data.object_y) - 25'(in_ch.data.point_y);

  assign sq_c = 32'(s1_zc) * 32'(s1_zc);
  assign sq_s = 32'(s1_zs) * 32'(s1_zs);
  assign m_c  = 26'(nlps_pkg::SinC) * 26'(s2_z2c);
  assign m_s  = 26'(nlps_pkg::SinC) * 26'(s2_z2s);
  assign t2_c = 30'(15'(nlps_pkg::SinB) - 15'(m_c >> 14)) * 30'(s2_z2c);
  assign t2_s = 30'(15'(nlps_pkg::SinB) - 15'(m_s >> 14)) * 30'(s2_z2s);
  assign sn_c = 30'(s3_tc) * 30'(s3_zc);
  assign sn_s = 30'(s3_ts) * 30'(s3_zs);
  assign pc = 52'(s4_hc) * 52'(s4_lc);
  assign ps = 52'(s4_hs) * 52'(s4_ls);
  assign dot = pc + ps;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
      s5_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_ch.valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
      s5_valid <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_it   <= in_ch.data;
      s1_wz   <= 34'(in_ch.data.quat_w) * 34'(in_ch.data.quat_z);
      s1_xy   <= 34'(in_ch.data.quat_x) * 34'(in_ch.data.quat_y);
      s1_yy   <= 34'(in_ch.data.quat_y) * 34'(in_ch.data.quat_y);
      s1_zz   <= 34'(in_ch.data.quat_z) * 34'(in_ch.data.quat_z);
      s1_dx2  <= 49'(dx) * 49'(dx);
      s1_dy2  <= 49'(dy) * 49'(dy);
      s1_zc   <= yaw_c[14] ? (nlps_pkg::QOne - 15'(yaw_c[13:0])) : 15'(yaw_c[13:0]);
      s1_zs   <= in_ch.data.point_yaw[14] ?
                 (nlps_pkg::QOne - 15'(in_ch.data.point_yaw[13:0])) :
                 15'(in_ch.data.point_yaw[13:0]);
      s1_negc <= yaw_c[15];
      s1_negs <= in_ch.data.point_yaw[15];

      s2_dist <= 50'(unsigned'(s1_dx2)) + 50'(unsigned'(s1_dy2));
      s2_hs   <= 36'(s1_wz + s1_xy) <<< 1;
      s2_hc   <= (36'sd1 <<< 28) - (36'(s1_yy + s1_zz) <<< 1);
      s2_zc   <= s1_zc;
      s2_zs   <= s1_zs;
      s2_z2c  <= 15'(sq_c >> 14);
      s2_z2s  <= 15'(sq_s >> 14);
      s2_negc <= s1_negc;
      s2_negs <= s1_negs;
      s2_j    <= s1_it.in_junction;
      s2_r    <= s1_it.point_radius_sq;
      s2_px   <= s1_it.point_x;
      s2_py   <= s1_it.point_y;
      s2_yaw  <= s1_it.point_yaw;
      s2_last <= s1_it.last_point;

      s3_dist <= s2_dist;
      s3_hs   <= s2_hs;
      s3_hc   <= s2_hc;
      s3_zc   <= s2_zc;
      s3_zs   <= s2_zs;
      s3_tc   <= nlps_pkg::SinA - 15'(t2_c >> 14);
      s3_ts   <= nlps_pkg::SinA - 15'(t2_s >> 14);
      s3_negc <= s2_negc;
      s3_negs <= s2_negs;
      s3_j    <= s2_j;
      s3_r    <= s2_r;
      s3_px   <= s2_px;
      s3_py   <= s2_py;
      s3_yaw  <= s2_yaw;
      s3_last <= s2_last;

      s4_dist <= s3_dist;
      s4_hs   <= s3_hs;
      s4_hc   <= (s3_hs == '0 && s3_hc == '0) ? 36'sd1 : s3_hc;
      s4_lc   <= s3_negc ? -16'(sn_c >> 14) : 16'(sn_c >> 14);
      s4_ls   <= s3_negs ? -16'(sn_s >> 14) : 16'(sn_s >> 14);
      s4_j    <= s3_j;
      s4_r    <= s3_r;
      s4_px   <= s3_px;
      s4_py   <= s3_py;
      s4_yaw  <= s3_yaw;
      s4_last <= s3_last;

      s5_dist <= s4_dist;
      s5_neg  <= dot[nlps_pkg::ProdW-1];
      s5_j    <= s4_j;
      s5_r    <= s4_r;
      s5_px   <= s4_px;
      s5_py   <= s4_py;
      s5_yaw  <= s4_yaw;
      s5_last <= s4_last;
    end
  end

  always_comb begin
    cand.keep_ok = !(s5_j && s5_neg) && (s5_dist < 50'(s5_r));
    cand.sq_dist = s5_dist;
    cand.radius  = s5_r;
    cand.px      = s5_px;
    cand.py      = s5_py;
    cand.yaw     = s5_yaw;
    cand.last    = s5_last;
  end

endmodule

>>> design/nlps_queue.sv
module nlps_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  nlps_pkg::cand_t wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output nlps_pkg::cand_t rd_data
);

  nlps_pkg::cand_t mem [2];
  logic       wp, rp;
  logic [1:0] cnt;

  assign wr_ready = cnt != 2'd2;
  assign rd_valid = cnt != 2'd0;
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) begin
      mem[wp] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (wr_valid && wr_ready) begin
        wp <= !wp;
      end
      if (rd_valid && rd_ready) begin
        rp <= !rp;
      end
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

>>> design/nlps_back.sv
module nlps_back #(
  parameter int unsigned MAX_POINTS = 4096
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cand_valid,
  output logic            cand_ready,
  input  nlps_pkg::cand_t cand,
  nlps_out_if.source      out_ch
);

  localparam int unsigned CntW = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_POINTS - 1);

  logic [nlps_pkg::DistW-1:0]       best_dist;
  logic signed [nlps_pkg::PosW-1:0] best_px, best_py;
  logic [nlps_pkg::YawW-1:0]        best_yaw;
  logic [CntW-1:0]                  best_slot, counter;
  logic                             hit;
  logic                             take, upd;

  assign cand_ready = !out_ch.valid || out_ch.ready;
  assign take = cand_valid && cand_ready;
  assign upd  = cand.keep_ok && (cand.sq_dist < best_dist);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_dist    <= '1;
      best_px      <= '0;
      best_py      <= '0;
      best_yaw     <= '0;
      best_slot    <= '0;
      hit          <= 1'b0;
      counter      <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (take && cand.last) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      if (take) begin
        if (cand.last) begin
          out_ch.data.found        <= hit || upd;
          out_ch.data.best_index   <= upd ? 12'(counter) : (hit ? 12'(best_slot) : '0);
          out_ch.data.best_x       <= upd ? cand.px : (hit ? best_px : '0);
          out_ch.data.best_y       <= upd ? cand.py : (hit ? best_py : '0);
          out_ch.data.best_yaw     <= upd ? cand.yaw : (hit ? best_yaw : '0);
          out_ch.data.best_dist_sq <= upd ? cand.sq_dist[nlps_pkg::RadW-1:0] :
                                      (hit ? best_dist[nlps_pkg::RadW-1:0] : '1);
          best_dist <= '1;
          best_px   <= '0;
          best_py   <= '0;
          best_yaw  <= '0;
          best_slot <= '0;
          hit       <= 1'b0;
          counter   <= '0;
        end else begin
          if (upd) begin
            best_dist <= cand.sq_dist;
            best_px   <= cand.px;
            best_py   <= cand.py;
            best_yaw  <= cand.yaw;
            best_slot <= counter;
            hit       <= 1'b1;
          end
          if (counter != CntMax) begin
            counter <= counter + 1'b1;
          end
        end
      end
    end
  end

endmodule
